[design/uartrb_pkg.sv]
// Request codes and shared types for the UART dual ring buffer.
package uartrb_pkg;

    typedef enum logic [2:0] {
        REQ_PUT      = 3'd0,
        REQ_GET      = 3'd1,
        REQ_TX_READY = 3'd2,
        REQ_RX_BYTE  = 3'd3,
        REQ_TX_FLUSH = 3'd4,
        REQ_RX_FLUSH = 3'd5
    } t_req_type;

    typedef struct packed {
        logic vld;
        logic from_rx;
        logic byte_vld;
        logic put_acc;
        logic overrun;
    } t_res_ctrl;

endpackage

[design/uartrb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module uartrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/uart_dual_ring_buffer_core.sv]
// Top level of the UART dual ring buffer: transmit and receive byte rings.
//
// A request (i_req_type, i_byte_in) is taken at a rising edge with start
// high and busy low. Codes: host put, host get, transmitter ready, byte
// received, flush transmit, flush receive; other codes only report levels.
// Each request gives one result, shown for exactly one cycle with o_strobe
// high from the result register, which follows the request register.
// The receiver cannot stall. While busy is low, a new request can be taken
// every cycle: the request is first registered, then the ring pointers
// and fill counts are updated and the ring RAM is read (registered read),
// and the result is driven from the RAM read register and the updated
// fill counts. Throughput is one request per cycle while busy is low.
// Reset (synchronous, active low) empties both rings and drops requests in
// flight; busy stays high during reset and drops in the cycle after it ends.
// Ring contents are not cleared; the fill counts keep unwritten slots from
// ever being read.
module uart_dual_ring_buffer_core #(
    parameter int RING_DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_byte_in,
    output logic       o_strobe,
    output logic [7:0] o_byte_out,
    output logic       o_byte_valid,
    output logic       o_put_accepted,
    output logic       o_rx_overrun,
    output logic [3:0] o_tx_level,
    output logic [3:0] o_rx_level,
    output logic       o_tx_irq_enable
);

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = $clog2(RING_DEPTH + 1);

    logic                   r_busy;
    logic                   r_req_vld;
    uartrb_pkg::t_req_type  r_req_type;
    logic [7:0]             r_req_byte;

    logic [PTR_W-1:0]  r_tx_rp, r_tx_wp, r_rx_rp, r_rx_wp;
    logic [PTR_W-1:0]  n_tx_rp, n_tx_wp, n_rx_rp, n_rx_wp;
    logic [FILL_W-1:0] r_tx_fill, r_rx_fill, n_tx_fill, n_rx_fill;

    uartrb_pkg::t_res_ctrl r_res, n_res;

    logic       tx_we, rx_we;
    logic [7:0] tx_rdata, rx_rdata;
    logic       tx_full, rx_full, tx_empty, rx_empty;

    logic [FILL_W+3:0] tx_fill_ext, rx_fill_ext;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_req_vld <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_req_vld <= start && !r_busy;
        end
        r_req_type <= uartrb_pkg::t_req_type'(i_req_type);
        r_req_byte <= i_byte_in;
    end

    assign tx_full  = (r_tx_fill == FILL_W'(RING_DEPTH));
    assign rx_full  = (r_rx_fill == FILL_W'(RING_DEPTH));
    assign tx_empty = (r_tx_fill == '0);
    assign rx_empty = (r_rx_fill == '0);

    always_comb begin
        n_tx_rp   = r_tx_rp;
        n_tx_wp   = r_tx_wp;
        n_tx_fill = r_tx_fill;
        n_rx_rp   = r_rx_rp;
        n_rx_wp   = r_rx_wp;
        n_rx_fill = r_rx_fill;
        tx_we     = 1'b0;
        rx_we     = 1'b0;
        n_res     = '0;
        n_res.vld = r_req_vld;
        if (r_req_vld) begin
            unique case (r_req_type)
                uartrb_pkg::REQ_PUT: begin
                    if (!tx_full) begin
                        tx_we         = 1'b1;
                        n_tx_wp       = advance(r_tx_wp);
                        n_tx_fill     = r_tx_fill + 1'b1;
                        n_res.put_acc = 1'b1;
                    end
                end
                uartrb_pkg::REQ_GET: begin
                    if (!rx_empty) begin
                        n_rx_rp        = advance(r_rx_rp);
                        n_rx_fill      = r_rx_fill - 1'b1;
                        n_res.byte_vld = 1'b1;
                        n_res.from_rx  = 1'b1;
                    end
                end
                uartrb_pkg::REQ_TX_READY: begin
                    if (!tx_empty) begin
                        n_tx_rp        = advance(r_tx_rp);
                        n_tx_fill      = r_tx_fill - 1'b1;
                        n_res.byte_vld = 1'b1;
                    end
                end
                uartrb_pkg::REQ_RX_BYTE: begin
                    rx_we   = 1'b1;
                    n_rx_wp = advance(r_rx_wp);
                    if (!rx_full) begin
                        n_rx_fill = r_rx_fill + 1'b1;
                    end else begin
                        n_rx_rp       = advance(r_rx_rp);
                        n_res.overrun = 1'b1;
                    end
                end
                uartrb_pkg::REQ_TX_FLUSH: begin
                    n_tx_rp   = '0;
                    n_tx_wp   = '0;
                    n_tx_fill = '0;
                end
                uartrb_pkg::REQ_RX_FLUSH: begin
                    n_rx_rp   = '0;
                    n_rx_wp   = '0;
                    n_rx_fill = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_rp   <= '0;
            r_tx_wp   <= '0;
            r_tx_fill <= '0;
            r_rx_rp   <= '0;
            r_rx_wp   <= '0;
            r_rx_fill <= '0;
            r_res     <= '0;
        end else begin
            r_tx_rp   <= n_tx_rp;
            r_tx_wp   <= n_tx_wp;
            r_tx_fill <= n_tx_fill;
            r_rx_rp   <= n_rx_rp;
            r_rx_wp   <= n_rx_wp;
            r_rx_fill <= n_rx_fill;
            r_res     <= n_res;
        end
    end

    uartrb_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wp),
        .i_wdata (r_req_byte),
        .i_raddr (r_tx_rp),
        .o_rdata (tx_rdata)
    );

    uartrb_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wp),
        .i_wdata (r_req_byte),
        .i_raddr (r_rx_rp),
        .o_rdata (rx_rdata)
    );

    assign tx_fill_ext = {4'b0, r_tx_fill};
    assign rx_fill_ext = {4'b0, r_rx_fill};

    assign busy            = r_busy;
    assign o_strobe        = r_res.vld;
    assign o_byte_valid    = r_res.vld && r_res.byte_vld;
    assign o_byte_out      = !o_byte_valid ? 8'h00 : (r_res.from_rx ? rx_rdata : tx_rdata);
    assign o_put_accepted  = r_res.vld && r_res.put_acc;
    assign o_rx_overrun    = r_res.vld && r_res.overrun;
    assign o_tx_level      = tx_fill_ext[3:0];
    assign o_rx_level      = rx_fill_ext[3:0];
    assign o_tx_irq_enable = !tx_empty;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_fill <= FILL_W'(RING_DEPTH)) && (r_rx_fill <= FILL_W'(RING_DEPTH)))
        else $error("ring fill count beyond depth");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("request without result two cycles later");

    a_put_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_put_accepted |-> o_tx_irq_enable)
        else $error("accepted put left transmit ring empty");

    a_overrun_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_overrun |-> (r_rx_fill == FILL_W'(RING_DEPTH)))
        else $error("overrun without full receive ring");

endmodule
